// ===== sv/eprk_pkg.sv =====
package eprk_pkg;

   // op codes of an input word
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_EDGE = 2'd1;
   localparam logic [1:0] OP_POLL = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] CSR_PROCESS_NOISE = 2'd0;
   localparam logic [1:0] CSR_MEASURE_NOISE = 2'd1;
   localparam logic [1:0] CSR_INIT_COV      = 2'd2;

   // register reset values, Q0.24 noise, Q8.24 covariance
   localparam logic [23:0] PROCESS_NOISE_RST = 24'd13422;
   localparam logic [23:0] MEASURE_NOISE_RST = 24'd33554;
   localparam logic [31:0] INIT_COV_RST      = 32'd167772160;

   // Q1.24 one, gain width (gain may reach exactly one)
   localparam int          FRAC_W  = 24;
   localparam int          GAIN_W  = 25;
   localparam logic [24:0] ONE_Q24 = 25'h100_0000;

   // centimetres per tick = 17 / 1000
   localparam logic [4:0]  CM_FACTOR  = 5'd17;
   localparam logic [9:0]  CM_DIVISOR = 10'd1000;

   // shared divider operand widths
   localparam int DIV_NUM_W = 56;   // p1 << 24
   localparam int DIV_DEN_W = 33;   // p1 + r

   // shared multiplier operand widths
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

endpackage

// ===== sv/eprk_div.sv =====
module eprk_div #(
   parameter int QUO_W = 25
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [eprk_pkg::DIV_NUM_W-1:0] num,
   input  logic [eprk_pkg::DIV_DEN_W-1:0] den,
   output logic                           done,
   output logic [QUO_W-1:0]               quo
);

   localparam int DEN_W = eprk_pkg::DIV_DEN_W;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // restoring divide, one quotient bit per cycle; quotient shifts in
   // where the low numerator bits shift out
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         // high part (p1 >> 1) is below den = p1 + r
         rem_in = DEN_W'(num >> QUO_W);
         quo_in = num[QUO_W-1:0];
         den_in = den;
         cnt_in = CNT_W'(QUO_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== sv/echo_pulse_range_kalman_core.sv =====
// Ticks, edges and polls with nothing new are taken while idle; a poll's word is
// registered at the accepting edge. A poll with a completed measurement runs two
// reciprocal multiplies for the distance, the divider load and 25 gain steps,
// three multiplies, write-back and hand-off, the input stalled meanwhile, so no
// new word is taken until that poll's word reaches the output register.
// Reset (synchronous): flags, count, estimate cleared, registers and covariance reloaded.
module echo_pulse_range_kalman_core #(
   parameter int OVERFLOW_BITS = 6
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_capture_count,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [16:0] rsp_distance_cm,
   output logic        rsp_fresh,

   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // ticks = overflows * 65536 + capture
   localparam int TICK_W = OVERFLOW_BITS + 16;
   // ticks * 17 / 1000 < 2^(TICK_W - 5)
   localparam int DIST_W = OVERFLOW_BITS + 11;
   localparam int EST_W  = DIST_W + eprk_pkg::FRAC_W;
   localparam int OUT_W  = 17;
   localparam int EXT_W  = (DIST_W > OUT_W) ? DIST_W : OUT_W;
   localparam int NUM_W  = eprk_pkg::DIV_NUM_W;
   localparam int DEN_W  = eprk_pkg::DIV_DEN_W;
   localparam int PW     = eprk_pkg::MUL_P_W;
   localparam int AW     = eprk_pkg::MUL_A_W;

   // distance = (ticks * K) >> RCP_SH, K = ceil(17 * 2^RCP_SH / 1000); with
   // ticks < 2^TICK_W the rounding error stays below 1/1000, so the floor is exact
   localparam int          RCP_SH = TICK_W + 10;
   localparam int          RSUM_W = 2 * TICK_W + 5;
   localparam logic [63:0] RCP_K  = ((64'(eprk_pkg::CM_FACTOR) << RCP_SH) +
                                     64'(eprk_pkg::CM_DIVISOR) - 64'd1) /
                                    64'(eprk_pkg::CM_DIVISOR);
   localparam logic [AW-1:0] RCP_LO = RCP_K[AW-1:0];
   localparam logic [AW-1:0] RCP_HI = RCP_K[2*AW-1:AW];

   // sequencer, one-hot
   typedef enum logic [8:0] {
      ST_IDLE    = 9'b0_0000_0001,
      ST_RCP_LO  = 9'b0_0000_0010,   // ticks * K[lo]
      ST_RCP_HI  = 9'b0_0000_0100,   // ticks * K[hi], sum gives the distance
      ST_GAIN    = 9'b0_0000_1000,   // p1 * 2^24 / (p1 + r) in the divider
      ST_MUL_HI  = 9'b0_0001_0000,   // gain * |d|[hi]
      ST_MUL_LO  = 9'b0_0010_0000,   // gain * |d|[lo]
      ST_MUL_COV = 9'b0_0100_0000,   // (1 - gain) * p1
      ST_UPDATE  = 9'b0_1000_0000,   // estimate and covariance write-back
      ST_RESP    = 9'b1_0000_0000    // hand result word to the output register
   } state_type;

   state_type state_ff, state_in;

   // measurement state
   logic                     done_flag_ff, done_flag_in;
   logic                     armed_ff, armed_in;
   logic [OVERFLOW_BITS-1:0] ovf_ff, ovf_in;
   logic [15:0]              cap_ff, cap_in;

   // filter state and config
   logic [EST_W-1:0]         est_ff, est_in;
   logic [31:0]              cov_ff, cov_in;
   logic [OUT_W-1:0]         last_ff, last_in;
   logic [23:0]              q_ff, q_in;
   logic [23:0]              r_ff, r_in;

   // working registers of one update
   logic [31:0]              p1_ff, p1_in;
   logic [eprk_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic [EST_W-1:0]         mag_ff, mag_in;
   logic                     up_ff, up_in;
   logic [PW-1:0]            prod_ff, prod_in;
   logic [EST_W-1:0]         acc_ff, acc_in;

   // result word register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]         rsp_dist_ff, rsp_dist_in;
   logic                     rsp_fresh_ff, rsp_fresh_in;

   // shared units
   logic                     div_start;
   logic [NUM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic                     div_done;
   logic [eprk_pkg::GAIN_W-1:0] div_quo;
   logic [eprk_pkg::MUL_A_W-1:0] mul_a;
   logic [eprk_pkg::MUL_B_W-1:0] mul_b;
   logic [PW-1:0]            mul_p;

   // helpers
   logic                     out_free;
   logic                     accept;
   logic [32:0]              p_sum;
   logic [31:0]              p1_sat;
   logic [TICK_W-1:0]        ticks;
   logic [RSUM_W-1:0]        rcp_sum;
   logic [DIST_W-1:0]        dist_cm;
   logic [EST_W-1:0]         meas_q24;
   logic [DEN_W-1:0]         gain_den;
   logic [EXT_W-1:0]         est_int;

   // output register may take a word this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // a poll needs the output register; ticks and edges do not
   assign req_stall = (state_ff != ST_IDLE) ||
                      ((req_op == eprk_pkg::OP_POLL) && !out_free);
   assign accept    = req_valid && !req_stall;

   // predicted covariance, saturated at 2^32 - 1
   assign p_sum  = {1'b0, cov_ff} + {9'b0, q_ff};
   assign p1_sat = p_sum[32] ? '1 : p_sum[31:0];

   assign ticks = {ovf_ff, cap_ff};

   // low partial product held in prod_ff, high one straight off the multiplier
   assign rcp_sum  = (RSUM_W'(mul_p) << AW) + RSUM_W'(prod_ff);
   assign dist_cm  = rcp_sum[RCP_SH +: DIST_W];
   assign meas_q24 = {dist_cm, 24'b0};
   assign gain_den = DEN_W'(p1_ff) + DEN_W'(r_ff);

   // divider only computes the gain
   assign div_start = (state_ff == ST_RCP_HI);
   assign div_num   = NUM_W'({p1_ff, 24'b0});
   assign div_den   = gain_den;

   eprk_div #(
      .QUO_W (eprk_pkg::GAIN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // shared multiplier, operands chosen by state
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_RCP_LO: begin
            mul_a = RCP_LO;
            mul_b = eprk_pkg::MUL_B_W'(ticks);
         end
         ST_RCP_HI: begin
            mul_a = RCP_HI;
            mul_b = eprk_pkg::MUL_B_W'(ticks);
         end
         ST_MUL_HI: begin
            mul_a = gain_ff;
            mul_b = eprk_pkg::MUL_B_W'(mag_ff[EST_W-1:eprk_pkg::FRAC_W]);
         end
         ST_MUL_LO: begin
            mul_a = gain_ff;
            mul_b = eprk_pkg::MUL_B_W'(mag_ff[eprk_pkg::FRAC_W-1:0]);
         end
         ST_MUL_COV: begin
            mul_a = eprk_pkg::ONE_Q24 - gain_ff;
            mul_b = p1_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PW'(mul_a) * PW'(mul_b);

   // integer part of the new estimate, fitted to the 17-bit result
   assign est_int = EXT_W'(est_in[EST_W-1:eprk_pkg::FRAC_W]);

   always_comb begin
      state_in     = state_ff;
      done_flag_in = done_flag_ff;
      armed_in     = armed_ff;
      ovf_in       = ovf_ff;
      cap_in       = cap_ff;
      est_in       = est_ff;
      cov_in       = cov_ff;
      last_in      = last_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      p1_in        = p1_ff;
      gain_in      = gain_ff;
      mag_in       = mag_ff;
      up_in        = up_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dist_in  = rsp_dist_ff;
      rsp_fresh_in = rsp_fresh_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  eprk_pkg::OP_TICK: begin
                     // counts only while armed; the last overflow closes the pulse
                     if (!done_flag_ff && armed_ff) begin
                        if (ovf_ff == '1) begin
                           done_flag_in = 1'b1;
                           cap_in       = 16'hFFFF;
                        end else begin
                           ovf_in = ovf_ff + OVERFLOW_BITS'(1);
                        end
                     end
                  end
                  eprk_pkg::OP_EDGE: begin
                     if (!done_flag_ff) begin
                        if (armed_ff) begin
                           done_flag_in = 1'b1;
                           cap_in       = req_capture_count;
                        end else begin
                           ovf_in   = '0;
                           cap_in   = '0;
                           armed_in = 1'b1;
                        end
                     end
                  end
                  eprk_pkg::OP_POLL: begin
                     if (done_flag_ff) begin
                        // distance by reciprocal multiply starts now
                        p1_in    = p1_sat;
                        state_in = ST_RCP_LO;
                     end else begin
                        // nothing new: repeat last distance
                        rsp_valid_in = 1'b1;
                        rsp_dist_in  = last_ff;
                        rsp_fresh_in = 1'b0;
                     end
                  end
                  default: begin
                     // unused op code: dropped
                  end
               endcase
            end
         end
         ST_RCP_LO: begin
            prod_in  = mul_p;
            state_in = ST_RCP_HI;
         end
         ST_RCP_HI: begin
            // measurement in Q24 parked in acc; gain divide starts now
            acc_in   = meas_q24;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            // innovation sign and magnitude, steady while the divider runs
            up_in  = (acc_ff >= est_ff);
            mag_in = (acc_ff >= est_ff) ? (acc_ff - est_ff) : (est_ff - acc_ff);
            if (div_done) begin
               // zero divisor gives zero gain
               gain_in  = (gain_den == '0) ? '0 : div_quo;
               state_in = ST_MUL_HI;
            end
         end
         ST_MUL_HI: begin
            prod_in  = mul_p;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            acc_in   = EST_W'(prod_ff);
            prod_in  = mul_p;
            state_in = ST_MUL_COV;
         end
         ST_MUL_COV: begin
            acc_in   = acc_ff + EST_W'(prod_ff >> eprk_pkg::FRAC_W);
            prod_in  = mul_p;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // step never exceeds |d|, so the estimate stays in range
            est_in   = up_ff ? (est_ff + acc_ff) : (est_ff - acc_ff);
            cov_in   = prod_ff[eprk_pkg::FRAC_W +: 32];
            last_in  = est_int[OUT_W-1:0];
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = last_ff;
               rsp_fresh_in = 1'b1;
               done_flag_in = 1'b0;
               armed_in     = 1'b0;
               ovf_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes must arrive only while idle; the block does not enforce it
      if (csr_write) begin
         unique case (csr_index)
            eprk_pkg::CSR_PROCESS_NOISE: q_in = csr_wdata[23:0];
            eprk_pkg::CSR_MEASURE_NOISE: r_in = csr_wdata[23:0];
            eprk_pkg::CSR_INIT_COV: begin
               // starting covariance goes straight into the filter
               cov_in = csr_wdata;
            end
            default: begin
               // no register at this index
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         done_flag_ff <= 1'b0;
         armed_ff     <= 1'b0;
         ovf_ff       <= '0;
         cap_ff       <= '0;
         est_ff       <= '0;
         cov_ff       <= eprk_pkg::INIT_COV_RST;
         last_ff      <= '0;
         q_ff         <= eprk_pkg::PROCESS_NOISE_RST;
         r_ff         <= eprk_pkg::MEASURE_NOISE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_flag_ff <= done_flag_in;
         armed_ff     <= armed_in;
         ovf_ff       <= ovf_in;
         cap_ff       <= cap_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         last_ff      <= last_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p1_ff        <= p1_in;
      gain_ff      <= gain_in;
      mag_ff       <= mag_in;
      up_ff        <= up_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_fresh_ff <= rsp_fresh_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_cm = rsp_dist_ff;
   assign rsp_fresh       = rsp_fresh_ff;

endmodule

// ===== dv/tb_echo_pulse_range_kalman_core.sv =====
module tb_echo_pulse_range_kalman_core;

   // op code 3 has no meaning in the block; it must be dropped silently
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [5:0] OVF_MAX   = 6'h3F;

   // settling wait after the queues drain; covers a fresh poll at the default width
   localparam int SETTLE_CYCLES = 64;
   // cycles with no word moving on either channel before we call it hung
   localparam int STALL_LIMIT   = 5000;
   // receiver hold-off used to back the block up into its input
   localparam int LONG_HOLD     = 400;

   // one word on the input channel
   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] cap;
   } pulse_word_type;

   // one word on the result channel
   typedef struct packed {
      logic [16:0] dist_cm;
      logic        fresh;
   } range_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = eprk_pkg::OP_TICK;
   logic [15:0] req_capture_count = 16'h0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [16:0] rsp_distance_cm;
   logic        rsp_fresh;

   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = eprk_pkg::CSR_PROCESS_NOISE;
   logic [31:0] csr_wdata = 32'h0;

   // words waiting to be offered, and results owed by the block
   pulse_word_type   pend_q[$];
   range_result_type range_exp_q[$];
   range_result_type want_res;

   // idle percentages per side, changed by the stimulus between phases
   int send_idle_pct = 22;
   int recv_idle_pct = 84;

   // long receiver hold-off, requested once by the stimulus
   bit hold_arm  = 1'b0;
   bit hold_used = 1'b0;
   int hold_cnt  = 0;

   int err_cnt     = 0;
   int idle_cycles = 0;

   // ------------------------------------------------------------------
   // Predictor state: filter registers plus the pulse timer and filter
   // ------------------------------------------------------------------
   logic [23:0] q_noise;
   logic [23:0] r_noise;
   logic        done_f;
   logic        armed_f;
   logic [5:0]  ovf_cnt;
   logic [15:0] cap_cnt;
   logic [63:0] est_q24;       // Q.24 estimate, 41 bits used
   logic [31:0] cov_q24;
   logic [16:0] last_cm;

   echo_pulse_range_kalman_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_capture_count (req_capture_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_distance_cm   (rsp_distance_cm),
      .rsp_fresh         (rsp_fresh),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mirror of a register write; the covariance register reload also
   // restarts the filter's error covariance.
   function automatic void filter_reg_write(input logic [1:0] idx, input logic [31:0] val);
      case (idx)
         eprk_pkg::CSR_PROCESS_NOISE: q_noise = val[23:0];
         eprk_pkg::CSR_MEASURE_NOISE: r_noise = val[23:0];
         eprk_pkg::CSR_INIT_COV:      cov_q24 = val;
         default: ;
      endcase
   endfunction

   // Advance the pulse timer / filter by one accepted word and queue the
   // result a poll owes.
   function automatic void range_step(input pulse_word_type w);
      logic [63:0]      ticks;
      logic [63:0]      dist_val;
      logic [63:0]      p1;
      logic [63:0]      sum;
      logic [63:0]      gain;
      logic [63:0]      meas;
      logic [63:0]      mag;
      logic [63:0]      delta;
      range_result_type res;
      case (w.op)
         eprk_pkg::OP_TICK: begin
            // ticks count only while a pulse is open
            if (!done_f && armed_f) begin
               if (ovf_cnt == OVF_MAX) begin
                  // pulse ran out the overflow counter: close it at full count
                  done_f  = 1'b1;
                  cap_cnt = 16'hFFFF;
               end else begin
                  ovf_cnt = ovf_cnt + 6'd1;
               end
            end
         end
         eprk_pkg::OP_EDGE: begin
            if (!done_f) begin
               if (armed_f) begin
                  done_f  = 1'b1;
                  cap_cnt = w.cap;
               end else begin
                  ovf_cnt = '0;
                  cap_cnt = '0;
                  armed_f = 1'b1;
               end
            end
         end
         eprk_pkg::OP_POLL: begin
            res.fresh = 1'b0;
            if (done_f) begin
               ticks    = (64'(ovf_cnt) << 16) + 64'(cap_cnt);
               dist_val = (ticks * 64'd17) / 64'd1000;
               // predict: p1 saturates at 32 bits
               p1 = 64'(cov_q24) + 64'(q_noise);
               if (p1 > 64'hFFFF_FFFF)
                  p1 = 64'hFFFF_FFFF;
               sum  = p1 + 64'(r_noise);
               gain = (sum != 64'd0) ? ((p1 << 24) / sum) : 64'd0;
               // correct: move toward the measurement, truncating toward zero
               meas  = dist_val << 24;
               mag   = (meas >= est_q24) ? (meas - est_q24) : (est_q24 - meas);
               delta = gain * (mag >> 24) + ((gain * (mag & 64'hFF_FFFF)) >> 24);
               if (meas >= est_q24)
                  est_q24 = est_q24 + delta;
               else
                  est_q24 = est_q24 - delta;
               cov_q24   = 32'(((64'(eprk_pkg::ONE_Q24) - gain) * p1) >> 24);
               last_cm   = est_q24[40:24];
               done_f    = 1'b0;
               armed_f   = 1'b0;
               ovf_cnt   = '0;
               res.fresh = 1'b1;
            end
            res.dist_cm = last_cm;
            range_exp_q.push_back(res);
         end
         default: ;   // unused op: no effect, no result
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers queued words, holds a stalled word steady
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            range_step('{op: req_op, cap: req_capture_count});
         if (!req_valid || !req_stall) begin
            if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid         <= 1'b1;
               req_op            <= pend_q[0].op;
               req_capture_count <= pend_q[0].cap;
               void'(pend_q.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver stall: random, or one long hold-off once requested
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cnt != 0) begin
         rsp_stall <= 1'b1;
         hold_cnt  <= hold_cnt - 1;
      end else if (hold_arm && !hold_used) begin
         rsp_stall <= 1'b1;
         hold_cnt  <= LONG_HOLD;
         hold_used <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every result word against the oldest owed result
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (range_exp_q.size() == 0) begin
            $display("%0t: result with none owed: dist=%0d fresh=%0b",
                     $time, rsp_distance_cm, rsp_fresh);
            err_cnt++;
         end else begin
            want_res = range_exp_q.pop_front();
            if (rsp_distance_cm !== want_res.dist_cm) begin
               $display("%0t: distance_cm expected %0d actual %0d",
                        $time, want_res.dist_cm, rsp_distance_cm);
               err_cnt++;
            end
            if (rsp_fresh !== want_res.fresh) begin
               $display("%0t: fresh expected %0b actual %0b",
                        $time, want_res.fresh, rsp_fresh);
               err_cnt++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: nothing moving for too long means the block is hung
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no traffic for %0d cycles", $time, STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_word(input logic [1:0] op, input logic [15:0] cap);
      pend_q.push_back('{op: op, cap: cap});
   endtask

   // Block until every queued word is taken and every owed result is back,
   // then let any silent tick/edge word finish.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pend_q.size() != 0 || req_valid || range_exp_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      filter_reg_write(idx, val);
   endtask

   task automatic load_filter_regs(input logic [23:0] q, input logic [23:0] r,
                                   input logic [31:0] p);
      csr_put(eprk_pkg::CSR_PROCESS_NOISE, 32'(q));
      csr_put(eprk_pkg::CSR_MEASURE_NOISE, 32'(r));
      csr_put(eprk_pkg::CSR_INIT_COV, p);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Mostly complete pulses (arm, overflows, close, poll) with random
   // counts; the rest single random words and pulses polled while open.
   // Only words that can change state or give a result count toward n.
   task automatic gen_traffic(input int n);
      int         made;
      int         kind;
      int         sel;
      int         nticks;
      logic [1:0] op;
      made = 0;
      while (made < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            sel    = $urandom_range(0, 99);
            nticks = (sel < 60) ? $urandom_range(0, 3) :
                     (sel < 85) ? $urandom_range(0, 63) : $urandom_range(60, 70);
            add_word(eprk_pkg::OP_EDGE, 16'($urandom));
            repeat (nticks) add_word(eprk_pkg::OP_TICK, 16'($urandom));
            if ($urandom_range(0, 9) == 0)
               add_word(eprk_pkg::OP_POLL, 16'($urandom));   // poll mid-pulse: stale
            add_word(eprk_pkg::OP_EDGE, 16'($urandom));
            add_word(eprk_pkg::OP_POLL, 16'($urandom));
            made += nticks + 3;
         end else if (kind < 88) begin
            op = 2'($urandom_range(0, 3));
            add_word(op, 16'($urandom));
            if (op == eprk_pkg::OP_EDGE || op == eprk_pkg::OP_POLL)
               made++;
         end else begin
            // pulse left open: polled without a falling edge
            nticks = $urandom_range(0, 5);
            add_word(eprk_pkg::OP_EDGE, 16'($urandom));
            repeat (nticks) add_word(eprk_pkg::OP_TICK, 16'($urandom));
            add_word(eprk_pkg::OP_POLL, 16'($urandom));
            made += nticks + 2;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      // predictor comes out of reset with the block
      q_noise = eprk_pkg::PROCESS_NOISE_RST;
      r_noise = eprk_pkg::MEASURE_NOISE_RST;
      done_f  = 1'b0;
      armed_f = 1'b0;
      ovf_cnt = '0;
      cap_cnt = '0;
      est_q24 = '0;
      cov_q24 = eprk_pkg::INIT_COV_RST;
      last_cm = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, reset register values
      add_word(eprk_pkg::OP_POLL, 16'h0000);   // nothing measured yet
      add_word(eprk_pkg::OP_TICK, 16'hFFFF);   // tick with no pulse open
      add_word(OP_UNUSED,         16'hFFFF);
      add_word(eprk_pkg::OP_EDGE, 16'h1234);   // rising edge, capture ignored
      add_word(eprk_pkg::OP_POLL, 16'h0000);   // pulse still open
      add_word(eprk_pkg::OP_EDGE, 16'h0000);   // zero-width pulse
      add_word(eprk_pkg::OP_TICK, 16'h0000);   // ignored once complete
      add_word(eprk_pkg::OP_EDGE, 16'hABCD);   // ignored once complete
      add_word(eprk_pkg::OP_POLL, 16'h5555);
      add_word(eprk_pkg::OP_EDGE, 16'hFFFF);
      add_word(eprk_pkg::OP_TICK, 16'h0000);
      add_word(eprk_pkg::OP_TICK, 16'h0000);
      add_word(eprk_pkg::OP_EDGE, 16'hFFFF);
      add_word(eprk_pkg::OP_POLL, 16'hAAAA);
      add_word(eprk_pkg::OP_POLL, 16'h0000);   // repeat of last distance
      add_word(eprk_pkg::OP_EDGE, 16'h0000);
      add_word(eprk_pkg::OP_EDGE, 16'h8000);
      add_word(eprk_pkg::OP_POLL, 16'h0000);
      add_word(OP_UNUSED,         16'h0000);
      add_word(eprk_pkg::OP_POLL, 16'hFFFF);
      gen_traffic(130);
      wait_idle();

      // smallest noise and covariance, busy receiver
      load_filter_regs(24'd0, 24'd1, 32'd1);
      gen_traffic(130);
      wait_idle();

      // largest values, covariance sum saturates; busy sender now
      send_idle_pct = 84;
      recv_idle_pct = 22;
      load_filter_regs(24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
      gen_traffic(130);
      wait_idle();

      load_filter_regs(24'($urandom), 24'($urandom_range(1, 24'hFF_FFFF)),
                       32'($urandom_range(1, 32'hFFFF_FFFF)));
      gen_traffic(130);
      wait_idle();

      // no idling: sender streams while the receiver holds off once
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_filter_regs(24'd0, 24'hFF_FFFF, 32'd1);
      gen_traffic(140);
      hold_arm = 1'b1;
      wait_idle();

      load_filter_regs(24'hFF_FFFF, 24'd1, 32'hFFFF_FFFF);
      gen_traffic(140);
      wait_idle();

      if (err_cnt == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/eprk_pkg.sv
sv/eprk_div.sv
sv/echo_pulse_range_kalman_core.sv
dv/tb_echo_pulse_range_kalman_core.sv
